// ===== design/sase_pkg.sv =====
// Shared types and constants for the sorted array search engine.
// No dependencies; used by sorted_array_search_engine_unit.
package sase_pkg;

  localparam int IDX_W = 9;   // index fields on the ports
  localparam int CNT_W = 10;  // comparison count and entries_in_use
  localparam int VAL_W = 32;  // item_value width on the port

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LINEAR = 2'd1,
    OP_BINARY = 2'd2,
    OP_EXPO   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIN,
    S_BIN,
    S_BIN_CMP,
    S_EXP,
    S_EXP_CMP,
    S_DONE
  } state_t;

endpackage

// ===== design/sorted_array_search_engine_unit.sv =====
// Sorted array search engine: element store plus linear, binary and
// exponential search sequencer. Depends on sase_pkg.
//
// Input channel (in_valid/in_ready): op, write_index, item_value,
//   low_index, high_index. A write item (op 0) stores item_value and gives
//   no result; a search item (op 1..3) gives one result item on the output
//   channel (out_valid/out_ready): found, found_index, comparisons.
// Config channel (cfg_valid/cfg_ready) loads entries_in_use; always ready.
//   Write it only while no search is in flight.
// Items are taken one at a time; searches use the one registered read port:
//   write       : stored on acceptance, the next item may follow at once
//   linear      : one entry read per cycle, comparing the previous read;
//                 ends on a hit or after the last entry (size - 1)
//   binary      : a read state, then a compare state, for each probe
//   exponential : doubling steps, each a read and a compare, until the
//                 entry is not below the value or ub reaches size,
//                 then its binary search as above
// The input is ready again from the cycle the result shows up.
// Reset: entries_in_use returns to 512, nothing in flight, output empty;
//   the element store is not cleared.
// Stall: a result sits in the output register until taken. Writes are still
//   accepted; a following search may run, then holds its result and blocks
//   the input until the output register frees up.
module sorted_array_search_engine_unit #(
  parameter int DEPTH     = 512,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sase_pkg::CNT_W-1:0]  entries_in_use,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [sase_pkg::IDX_W-1:0]  write_index,
  input  logic signed [sase_pkg::VAL_W-1:0] item_value,
  input  logic [sase_pkg::IDX_W-1:0]  low_index,
  input  logic [sase_pkg::IDX_W-1:0]  high_index,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [sase_pkg::IDX_W-1:0]  found_index,
  output logic [sase_pkg::CNT_W-1:0]  comparisons
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // signed working width for indices and bounds; room for -1 and 2*size
  localparam int IW  = ((AW > sase_pkg::CNT_W) ? AW : sase_pkg::CNT_W) + 2;
  localparam logic signed [IW-1:0] DEPTH_I = IW'(DEPTH);
  localparam logic signed [IW-1:0] LAST_I  = IW'(DEPTH - 1);
  localparam logic signed [IW-1:0] ONE_I   = IW'(1);

  sase_pkg::state_t state, state_next;

  // element store
  logic [WORD_BITS-1:0]        mem [DEPTH];
  logic signed [WORD_BITS-1:0] rd_data;
  logic                        rd_en;
  logic signed [IW-1:0]        rd_idx;
  logic                        wr_en;

  // config register
  logic [sase_pkg::CNT_W-1:0]  entries;

  // search context
  logic signed [WORD_BITS-1:0] val;
  logic signed [IW-1:0]        lo, hi, mid, ptr, cmp_idx, ub;
  logic                        pend;
  logic [sase_pkg::CNT_W-1:0]  cnt;
  logic                        res_found;
  logic signed [IW-1:0]        res_idx;

  // combinational helpers
  logic signed [63:0]          val64;
  logic signed [WORD_BITS-1:0] val_in;
  logic signed [IW-1:0]        size;
  logic signed [IW-1:0]        wi_ext, lo_ext, hi_ext, hi_clamp;
  logic signed [IW:0]          mid_sum;
  logic signed [IW-1:0]        mid_c, lb_c, ub_c, lb_raw;
  logic                        in_acc, load_out, out_free;
  logic                        lin_match, lin_last, bin_eq, bin_gt, exp_lt;
  logic                        lin_issue;
  sase_pkg::op_t               op_c;

  assign op_c   = sase_pkg::op_t'(op);
  // cut to the stored word width after sign extension
  assign val64  = 64'(item_value);
  assign val_in = val64[WORD_BITS-1:0];

  assign size   = ($signed({{(IW-sase_pkg::CNT_W){1'b0}}, entries}) > DEPTH_I) ?
                  DEPTH_I : $signed({{(IW-sase_pkg::CNT_W){1'b0}}, entries});
  assign wi_ext = $signed({{(IW-sase_pkg::IDX_W){1'b0}}, write_index});
  assign lo_ext = $signed({{(IW-sase_pkg::IDX_W){1'b0}}, low_index});
  assign hi_ext = $signed({{(IW-sase_pkg::IDX_W){1'b0}}, high_index});
  assign hi_clamp = (hi_ext > LAST_I) ? LAST_I : hi_ext;

  // lo and hi are both non-negative whenever a probe is issued
  assign mid_sum = {lo[IW-1], lo} + {hi[IW-1], hi};
  assign mid_c   = mid_sum[IW:1];

  // exponential: interval ub/2-1 .. ub, clamped into the array
  assign lb_raw = (ub >>> 1) - ONE_I;
  assign lb_c   = (lb_raw < 0) ? '0 : lb_raw;
  assign ub_c   = (ub > size - ONE_I) ? (size - ONE_I) : ub;

  assign lin_issue = (ptr < size);
  assign lin_match = pend && (rd_data == val);
  assign lin_last  = (cmp_idx == size - ONE_I);
  assign bin_eq    = (rd_data == val);
  assign bin_gt    = (rd_data > val);
  assign exp_lt    = (rd_data < val);

  assign out_free  = !out_valid || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (op_c == sase_pkg::OP_WRITE) && (wi_ext < DEPTH_I);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sase_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op_c)
            sase_pkg::OP_LINEAR: state_next = (size == 0) ? sase_pkg::S_DONE
                                                          : sase_pkg::S_LIN;
            sase_pkg::OP_BINARY: state_next = sase_pkg::S_BIN;
            sase_pkg::OP_EXPO:   state_next = (size == 0) ? sase_pkg::S_DONE
                                                          : sase_pkg::S_EXP;
            default:             state_next = sase_pkg::S_IDLE;
          endcase
        end
      end
      sase_pkg::S_LIN: begin
        if (pend && (lin_match || lin_last)) state_next = sase_pkg::S_DONE;
      end
      sase_pkg::S_BIN: begin
        state_next = (lo > hi) ? sase_pkg::S_DONE : sase_pkg::S_BIN_CMP;
      end
      sase_pkg::S_BIN_CMP: begin
        state_next = bin_eq ? sase_pkg::S_DONE : sase_pkg::S_BIN;
      end
      sase_pkg::S_EXP: begin
        state_next = (ub < size) ? sase_pkg::S_EXP_CMP : sase_pkg::S_BIN;
      end
      sase_pkg::S_EXP_CMP: begin
        state_next = exp_lt ? sase_pkg::S_EXP : sase_pkg::S_BIN;
      end
      sase_pkg::S_DONE: begin
        if (out_free) state_next = sase_pkg::S_IDLE;
      end
      default: state_next = sase_pkg::S_IDLE;
    endcase
  end

  // control outputs and memory read port
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = ptr;
    load_out = 1'b0;
    case (state)
      sase_pkg::S_IDLE: in_ready = 1'b1;
      sase_pkg::S_LIN: begin
        rd_en  = lin_issue;
        rd_idx = ptr;
      end
      sase_pkg::S_BIN: begin
        rd_en  = !(lo > hi);
        rd_idx = mid_c;
      end
      sase_pkg::S_EXP: begin
        rd_en  = (ub < size);
        rd_idx = ub - ONE_I;
      end
      sase_pkg::S_DONE: load_out = out_free;
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wi_ext[AW-1:0]] <= val_in;
    if (rd_en) rd_data <= mem[rd_idx[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sase_pkg::S_IDLE;
      out_valid <= 1'b0;
      entries   <= sase_pkg::CNT_W'(512);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) entries <= entries_in_use;
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      sase_pkg::S_IDLE: begin
        if (in_acc) begin
          val       <= val_in;
          lo        <= lo_ext;
          hi        <= hi_clamp;
          ub        <= ONE_I;
          ptr       <= '0;
          pend      <= 1'b0;
          cnt       <= '0;
          res_found <= 1'b0;
          res_idx   <= '0;
        end
      end
      sase_pkg::S_LIN: begin
        // issue one read per cycle, compare the previous one
        if (lin_issue) ptr <= ptr + ONE_I;
        pend    <= lin_issue;
        cmp_idx <= ptr;
        if (pend) begin
          cnt <= cnt + 1'b1;
          if (lin_match) begin
            res_found <= 1'b1;
            res_idx   <= cmp_idx;
          end
        end
      end
      sase_pkg::S_BIN: begin
        mid <= mid_c;
      end
      sase_pkg::S_BIN_CMP: begin
        cnt <= cnt + 1'b1;
        if (bin_eq) begin
          res_found <= 1'b1;
          res_idx   <= mid;
        end else if (bin_gt) begin
          hi <= mid - ONE_I;
        end else begin
          lo <= mid + ONE_I;
        end
      end
      sase_pkg::S_EXP: begin
        if (!(ub < size)) begin
          lo <= lb_c;
          hi <= ub_c;
        end
      end
      sase_pkg::S_EXP_CMP: begin
        if (exp_lt) begin
          cnt <= cnt + 1'b1;
          ub  <= ub <<< 1;
        end else begin
          lo <= lb_c;
          hi <= ub_c;
        end
      end
      default: begin
        pend <= pend;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      found       <= res_found;
      found_index <= res_found ? res_idx[sase_pkg::IDX_W-1:0] : '0;
      comparisons <= cnt;
    end
  end

endmodule
